// ===== src/drsr_pkg.sv =====
package drsr_pkg;

    localparam int CH_W    = 8;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 11;
    localparam int DIG_W   = 4;
    localparam int NDIG    = 5;
    localparam int NDIG_W  = 3;

    localparam int MAX_LEN = 1024;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN - 1);
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    localparam logic [CH_W-1:0] ASCII_0   = 8'h30;
    localparam logic [CH_W-1:0] ASCII_9   = 8'h39;
    localparam logic [CH_W-1:0] CH_END    = 8'h00;

    // v / 10 == (v * 0xCCCD) >> 19 for every 16-bit v
    localparam logic [15:0] DIV10_MAGIC = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_DIGS = 4'b0100,
        ST_TAIL = 4'b1000
    } state_t;

endpackage

// ===== src/drsr_ifs.sv =====
interface drsr_in_if;
    logic                       valid;
    logic                       ready;
    logic [drsr_pkg::CH_W-1:0]  ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface drsr_out_if;
    logic                       valid;
    logic                       ready;
    logic [drsr_pkg::CH_W-1:0]  out_ch;
    logic                       last_of_run;
    logic                       end_of_text;

    modport source (output valid, output out_ch, output last_of_run, output end_of_text,
                    input ready);
    modport sink   (input valid, input out_ch, input last_of_run, input end_of_text,
                    output ready);
endinterface

// ===== src/digit_run_sum_rewriter_top.sv =====
// Digit run sum rewriter. Text bytes enter one item per byte on din; a zero
// byte ends the text. Each maximal run of ASCII digits comes out as the decimal
// text of the sum of its digit values (saturating at 65535), most significant
// digit first, as soon as the next non-digit or the terminator arrives; every
// other byte is copied. A copied byte is dropped once MAX_LEN - 1 bytes
// (drsr_pkg) have been sent in the current text; sum digits and the closing
// zero byte are never dropped. The closing zero byte carries end_of_text, the
// final result of each input item carries last_of_run, and the terminator
// clears all state for the next text. A digit item is added to the run sum
// as it is accepted. A non-digit or terminator is accepted, then its byte is
// handled in ST_TAIL; when a run is pending, the sum's digits (1 to 5) come
// first: one shared divide-by-ten unit (a constant multiply and
// a subtract) peels one digit per cycle, then one digit per cycle leaves
// through the output register while it is not stalled. din.ready is high only
// while the sequencer is idle; output back-pressure stalls the sequencer.
module digit_run_sum_rewriter_top (
    input  logic        clk,
    input  logic        rst_n,
    drsr_in_if.sink     din,
    drsr_out_if.source  dout
);
    import drsr_pkg::*;

    state_t             state_reg, state_next;
    logic [SUM_W-1:0]   run_sum_reg, run_sum_next;
    logic               in_run_reg, in_run_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NDIG_W-1:0]  n_reg, n_next;
    logic [NDIG_W-1:0]  idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    // payload, no reset
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [SUM_W-1:0]   v_reg, v_next;
    logic [DIG_W-1:0]   dig_reg [NDIG];
    logic [CH_W-1:0]    out_ch_reg, out_ch_next;
    logic               last_reg, last_next;
    logic               eot_reg, eot_next;
    logic               dig_we;

    logic               is_digit;
    logic               slot_free;
    logic [CNT_W-1:0]   cnt_inc;
    logic [SUM_W:0]     sum_add;
    logic [31:0]        prod;
    logic [SUM_W-1:0]   quot;
    logic [SUM_W-1:0]   quot_x10;
    logic [SUM_W-1:0]   rem_full;
    logic [DIG_W-1:0]   rem;

    assign is_digit  = (din.ch >= ASCII_0) && (din.ch <= ASCII_9);
    assign slot_free = !out_valid_reg || dout.ready;
    assign cnt_inc   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
    assign sum_add   = {1'b0, run_sum_reg} + (SUM_W+1)'(din.ch - ASCII_0);

    // shared divide-by-ten unit: quotient by reciprocal, remainder by subtract
    assign prod     = v_reg * DIV10_MAGIC;
    assign quot     = SUM_W'(prod >> DIV10_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = v_reg - quot_x10;
    assign rem      = rem_full[DIG_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        run_sum_next   = run_sum_reg;
        in_run_next    = in_run_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        v_next         = v_reg;
        dig_we         = 1'b0;
        out_ch_next    = out_ch_reg;
        last_next      = last_reg;
        eot_next       = eot_reg;
        out_valid_next = out_valid_reg && !dout.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    if (is_digit)
                    begin
                        // accumulate the run, saturating
                        run_sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                        in_run_next  = 1'b1;
                    end
                    else
                    begin
                        ch_next = din.ch;
                        if (in_run_reg)
                        begin
                            v_next       = run_sum_reg;
                            run_sum_next = '0;
                            in_run_next  = 1'b0;
                            n_next       = '0;
                            state_next   = ST_CONV;
                        end
                        else
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_CONV:
            begin
                // peel one digit, least significant first
                dig_we = 1'b1;
                n_next = n_reg + NDIG_W'(1);
                v_next = quot;
                if ((quot == '0) || (n_reg == NDIG_W'(NDIG - 1)))
                begin
                    idx_next   = n_reg;
                    state_next = ST_DIGS;
                end
            end
            ST_DIGS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ASCII_0 + CH_W'(dig_reg[idx_reg]);
                    eot_next       = 1'b0;
                    // last digit closes the item when the copied byte will be dropped
                    last_next      = (idx_reg == '0) && (ch_reg != CH_END)
                                     && !(cnt_inc < CNT_LIMIT);
                    cnt_next       = cnt_inc;
                    if (idx_reg == '0)
                        state_next = ST_TAIL;
                    else
                        idx_next = idx_reg - NDIG_W'(1);
                end
            end
            ST_TAIL:
            begin
                if (ch_reg == CH_END)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_ch_next    = CH_END;
                        last_next      = 1'b1;
                        eot_next       = 1'b1;
                        run_sum_next   = '0;
                        in_run_next    = 1'b0;
                        cnt_next       = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (cnt_reg < CNT_LIMIT)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_ch_next    = ch_reg;
                        last_next      = 1'b1;
                        eot_next       = 1'b0;
                        cnt_next       = cnt_inc;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // drop the byte
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_sum_reg   <= '0;
            in_run_reg    <= 1'b0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_sum_reg   <= run_sum_next;
            in_run_reg    <= in_run_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        v_reg      <= v_next;
        out_ch_reg <= out_ch_next;
        last_reg   <= last_next;
        eot_reg    <= eot_next;
        if (dig_we)
            dig_reg[n_reg] <= rem;
    end

    assign din.ready        = (state_reg == ST_IDLE);
    assign dout.valid       = out_valid_reg;
    assign dout.out_ch      = out_ch_reg;
    assign dout.last_of_run = last_reg;
    assign dout.end_of_text = eot_reg;

endmodule

// ===== src/drsr_checker.sv =====
module drsr_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [drsr_pkg::CH_W-1:0]  in_ch,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [drsr_pkg::CH_W-1:0]  out_ch,
    input  logic                       out_last,
    input  logic                       out_eot
);
    import drsr_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ch)
                                    && $stable(out_last) && $stable(out_eot))
        else $error("stalled result changed");

    // closing byte is zero and ends the item
    a_eot_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_eot |-> out_last && (out_ch == CH_END))
        else $error("malformed end of text");

    // a non-digit item keeps the input closed the next cycle
    a_busy_after_nondigit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !((in_ch >= ASCII_0) && (in_ch <= ASCII_9)) |=> !in_ready)
        else $error("input reopened during a non-digit item");

    // a digit item produces nothing in the following cycle
    a_digit_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_ch >= ASCII_0) && (in_ch <= ASCII_9) && !out_valid
        |=> !out_valid)
        else $error("digit item produced a result");

endmodule

bind digit_run_sum_rewriter_top drsr_checker u_drsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_ch     (din.ch),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_ch    (dout.out_ch),
    .out_last  (dout.last_of_run),
    .out_eot   (dout.end_of_text)
);
